// ----- hw/rtl/maods_pkg.sv -----
package maods_pkg;

  localparam int unsigned MaxDim   = 1024;
  localparam int unsigned IdxW     = $clog2(MaxDim);
  localparam int unsigned BoundW   = IdxW + 1;
  localparam int unsigned MagW     = 63;
  localparam logic [MagW-1:0] InfBits = 63'h7FF0000000000000;

  localparam logic [0:0] CfgRowStart = 1'b0;
  localparam logic [0:0] CfgRowEnd   = 1'b1;

  // One classified candidate passed from front to back
  typedef struct packed {
    logic            take;
    logic            last;
    logic [MagW-1:0] mag;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } cand_t;

endpackage

// ----- hw/rtl/max_abs_off_diagonal_search_unit.sv -----
// Pivot search for a Jacobi sweep: scans a stream of double elements, keeps
// strictly-lower elements whose row lies in [row_start, row_end) (row_start 0
// means 1), and on the element with tlast emits the largest sign-cleared
// magnitude with its row and column (all zero if none), then restarts. NaNs
// are skipped; ties keep the earliest element. One element per cycle unless the
// queue is full; a result passes through the queue (classify/queue) and then the
// compare register. A two-entry queue between the classifier and the compare stage
// absorbs output stalls. Write configuration only while idle.
module max_abs_off_diagonal_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // [63:0] element_bits, [73:64] elem_row,
                                  // [83:74] elem_col, [87:84] zero
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [62:0] max_magnitude, [72:63] max_row,
                                  // [82:73] max_col, [87:83] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [maods_pkg::BoundW-1:0] row_start_r, row_end_r;
  logic                         q_valid, q_ready;
  maods_pkg::cand_t             q_data;
  logic [maods_pkg::MagW-1:0]   o_mag;
  logic [maods_pkg::IdxW-1:0]   o_row, o_col;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_start_r <= maods_pkg::BoundW'(1);
      row_end_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        maods_pkg::CfgRowStart: row_start_r <= cfg_data;
        maods_pkg::CfgRowEnd:   row_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  maods_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_element_bits(in_tdata[63:0]),
    .in_row(in_tdata[73:64]),
    .in_col(in_tdata[83:74]),
    .in_last(in_tlast),
    .row_start(row_start_r), .row_end(row_end_r),
    .q_valid, .q_ready, .q_data
  );

  maods_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_tvalid, .out_tready,
    .out_mag(o_mag), .out_row(o_row), .out_col(o_col)
  );

  assign out_tdata = {5'b0, o_col, o_row, o_mag};

endmodule

// ----- hw/rtl/maods_front.sv -----
module maods_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_element_bits,
  input  logic [maods_pkg::IdxW-1:0]      in_row,
  input  logic [maods_pkg::IdxW-1:0]      in_col,
  input  logic                            in_last,
  input  logic [maods_pkg::BoundW-1:0]    row_start,
  input  logic [maods_pkg::BoundW-1:0]    row_end,
  output logic                            q_valid,
  input  logic                            q_ready,
  output maods_pkg::cand_t                q_data
);

  localparam int unsigned Depth = 2;

  maods_pkg::cand_t            mem_r [Depth];
  logic                        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic [maods_pkg::BoundW-1:0] lo;
  logic [maods_pkg::BoundW-1:0] row_ext;
  logic                        in_win, lower, not_nan;
  logic [maods_pkg::MagW-1:0]  mag;
  maods_pkg::cand_t            c;
  logic                        push, pop;

  // Classify the incoming element
  always_comb begin
    mag     = in_element_bits[maods_pkg::MagW-1:0];
    lo      = (row_start == '0) ? maods_pkg::BoundW'(1) : row_start;
    row_ext = {1'b0, in_row};
    in_win  = (row_ext >= lo) && (row_ext < row_end);
    lower   = in_col < in_row;
    not_nan = mag <= maods_pkg::InfBits;
    c.take  = in_win && lower && not_nan;
    c.last  = in_last;
    c.mag   = mag;
    c.row   = in_row;
    c.col   = in_col;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_data    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store a request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= c;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready) else $error("accept while full");
  a_empty_novalid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !q_valid) else $error("valid while empty");
`endif

endmodule

// ----- hw/rtl/maods_back.sv -----
module maods_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  maods_pkg::cand_t              q_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [maods_pkg::MagW-1:0]    out_mag,
  output logic [maods_pkg::IdxW-1:0]    out_row,
  output logic [maods_pkg::IdxW-1:0]    out_col
);

  logic [maods_pkg::MagW-1:0] best_mag_r, best_mag_nxt;
  logic [maods_pkg::IdxW-1:0] best_row_r, best_row_nxt, best_col_r, best_col_nxt;
  logic                       ovalid_r;
  logic [maods_pkg::MagW-1:0] omag_r;
  logic [maods_pkg::IdxW-1:0] orow_r, ocol_r;
  logic                       go, upd;

  // Stall only when a result waits and another last would overwrite it
  assign q_ready = !(ovalid_r && !out_tready && q_data.last);
  assign go      = q_valid && q_ready;
  assign upd     = q_data.take && (q_data.mag > best_mag_r);

  always_comb begin
    best_mag_nxt = upd ? q_data.mag : best_mag_r;
    best_row_nxt = upd ? q_data.row : best_row_r;
    best_col_nxt = upd ? q_data.col : best_col_r;
  end

  // Track running maximum; clear after last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_mag_r <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      if (go) begin
        if (q_data.last) begin
          best_mag_r <= '0;
          best_row_r <= '0;
          best_col_r <= '0;
          ovalid_r   <= 1'b1;
        end else begin
          best_mag_r <= best_mag_nxt;
          best_row_r <= best_row_nxt;
          best_col_r <= best_col_nxt;
        end
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (go && q_data.last) begin
      omag_r <= best_mag_nxt;
      orow_r <= best_row_nxt;
      ocol_r <= best_col_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_mag    = omag_r;
  assign out_row    = orow_r;
  assign out_col    = ocol_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (go && q_data.last) |=> (best_mag_r == '0) && out_tvalid)
    else $error("state not cleared after last");
  a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !q_data.last) |=> (best_mag_r >= $past(best_mag_r)))
    else $error("best magnitude fell");
  a_no_nan_best: assert property (@(posedge clk) disable iff (!rst_n)
    best_mag_r <= maods_pkg::InfBits) else $error("NaN taken");
`endif

endmodule
